/* rtl/bcdm_pkg.sv */
// Shared types, constants and digit helpers for the BCD long multiplier.
// No dependencies; every other file in rtl/ imports this package.
package bcdm_pkg;

  // Fixed port geometry: 16 BCD digits per 64-bit word, 32-digit product.
  localparam int WORD_W         = 64;
  localparam int WORD_DIGITS    = 16;
  localparam int PRODUCT_DIGITS = 32;
  localparam int SIG_W          = 6;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] carry_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_ROW     = 4'b0010,
    ST_RESOLVE = 4'b0100,
    ST_COUNT   = 4'b1000
  } state_t;

  // Product of two decimal digits, returned as {tens, ones}.
  // The tens digit uses a multiply by 205 and a shift by 11 in place of a divide by ten.
  function automatic logic [7:0] digit_mul(input digit_t a, input digit_t d);
    logic [6:0]  p;
    logic [15:0] q;
    digit_t      tens;
    digit_t      ones;
    p    = 7'(a * d);
    q    = 16'(p) * 16'd205;
    tens = q[14:11];
    ones = 4'(p - 7'(tens) * 7'd10);
    return {tens, ones};
  endfunction

endpackage

/* rtl/bcdm_row_unit.sv */
// Shared decimal row unit: adds multiplicand times one digit into the running
// digits in carry-save form. Depends on bcdm_pkg.
module bcdm_row_unit #(
  parameter int DIGITS = 16
) (
  input  logic [DIGITS-1:0][3:0] multiplicand,
  input  bcdm_pkg::digit_t       digit,
  input  logic [DIGITS-1:0][3:0] acc,
  input  logic [DIGITS-1:0][1:0] carry_in,
  output logic [DIGITS-1:0][3:0] sum,
  output logic [DIGITS-1:0][1:0] carry_out,
  output bcdm_pkg::digit_t       top_tens
);
  import bcdm_pkg::*;

  logic [DIGITS-1:0][7:0] part;

  // Digit products of the multiplicand with the current digit.
  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      part[j] = digit_mul(multiplicand[j], digit);
    end
  end

  // Each position sums its own digit, the product's ones, the tens from the
  // position below and the saved carry. Carries are kept, not propagated.
  always_comb begin
    logic [4:0] t;
    digit_t     tens_below;
    for (int j = 0; j < DIGITS; j++) begin
      tens_below = (j == 0) ? 4'd0 : part[(j == 0) ? 0 : j - 1][7:4];
      t = 5'(acc[j]) + 5'(part[j][3:0]) + 5'(tens_below) + 5'(carry_in[j]);
      if (t >= 5'd20) begin
        carry_out[j] = 2'd2;
        sum[j]       = 4'(t - 5'd20);
      end else if (t >= 5'd10) begin
        carry_out[j] = 2'd1;
        sum[j]       = 4'(t - 5'd10);
      end else begin
        carry_out[j] = 2'd0;
        sum[j]       = 4'(t);
      end
    end
  end

  assign top_tens = part[DIGITS-1][7:4];

endmodule

/* rtl/bcdm_digit_count.sv */
// Counts the significant digits of the 32-digit product (one for zero).
// Depends on bcdm_pkg.
module bcdm_digit_count (
  input  logic [bcdm_pkg::PRODUCT_DIGITS-1:0][3:0] product,
  output logic [bcdm_pkg::SIG_W-1:0]               count
);
  import bcdm_pkg::*;

  // The highest nonzero digit decides; later matches override earlier ones.
  always_comb begin
    count = SIG_W'(1);
    for (int k = 0; k < PRODUCT_DIGITS; k++) begin
      if (product[k] != 4'd0) begin
        count = SIG_W'(k + 1);
      end
    end
  end

endmodule

/* rtl/bcd_long_multiplier.sv */
// BCD long multiplier, top level.
// Uses bcdm_pkg, bcdm_row_unit and bcdm_digit_count.
//
// Usage: drive multiplicand_digits and multiplier_digits (packed BCD, least
// significant digit in bits 3..0, the low DIGITS nibbles used) and pulse start
// while busy is low; the item is taken at that clock edge. busy stays high while
// the item is worked on. The result appears on product_upper, product_lower,
// significant_digits and bad_digit for exactly one cycle, marked by done.
// The receiver cannot stall; a result must be taken in its done cycle.
//
// After an item is taken the sequencer folds in the rows in ST_ROW, then settles
// carries in ST_RESOLVE before done. One multiplier digit is folded in per
// cycle through the shared row unit, which keeps carries in saved form; the
// settling passes reuse the same unit with a zero digit until no carry is left.
// ST_COUNT counts the significant digits. A new item can already be taken while
// done is high. An item with a nibble above 9 gets its result (zero product,
// one digit, bad_digit set) in the cycle after it is taken, without going busy.
//
// Reset clears the sequencer and the done strobe; no result is pending after it.
module bcd_long_multiplier #(
  parameter int DIGITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bcdm_pkg::WORD_W-1:0]    multiplicand_digits,
  input  logic [bcdm_pkg::WORD_W-1:0]    multiplier_digits,
  output logic                           done,
  output logic [bcdm_pkg::WORD_W-1:0]    product_upper,
  output logic [bcdm_pkg::WORD_W-1:0]    product_lower,
  output logic [bcdm_pkg::SIG_W-1:0]     significant_digits,
  output logic                           bad_digit
);
  import bcdm_pkg::*;

  localparam int CNT_W = (DIGITS < 2) ? 1 : $clog2(DIGITS);

  state_t                 state;
  logic [CNT_W-1:0]       row_cnt;
  logic [DIGITS-1:0][3:0] mcand;
  logic [DIGITS-1:0][3:0] mplier;
  logic [DIGITS-1:0][3:0] hi;
  logic [DIGITS-1:0][1:0] cy;
  logic [DIGITS-1:0][3:0] lo;

  logic [DIGITS-1:0][3:0] row_sum;
  logic [DIGITS-1:0][1:0] row_carry;
  digit_t                 row_top;
  digit_t                 row_digit;
  logic                   in_bad;
  logic                   accept;

  logic [PRODUCT_DIGITS-1:0][3:0] full;
  logic [SIG_W-1:0]               sig_count;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Any used input nibble above 9 flags the item.
  always_comb begin
    in_bad = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (multiplicand_digits[4*i +: 4] > 4'd9 || multiplier_digits[4*i +: 4] > 4'd9) begin
        in_bad = 1'b1;
      end
    end
  end

  // The row unit sees the current multiplier digit, or zero while carries settle.
  assign row_digit = (state == ST_ROW) ? mplier[0] : 4'd0;

  bcdm_row_unit #(
    .DIGITS(DIGITS)
  ) u_row (
    .multiplicand(mcand),
    .digit       (row_digit),
    .acc         (hi),
    .carry_in    (cy),
    .sum         (row_sum),
    .carry_out   (row_carry),
    .top_tens    (row_top)
  );

  // Place the finished digits into the 32-digit product.
  for (genvar k = 0; k < PRODUCT_DIGITS; k++) begin : g_full
    if (k < DIGITS) begin : g_lo
      assign full[k] = lo[k];
    end else if (k < 2 * DIGITS) begin : g_hi
      assign full[k] = hi[k - DIGITS];
    end else begin : g_zero
      assign full[k] = 4'd0;
    end
  end

  bcdm_digit_count u_count (
    .product(full),
    .count  (sig_count)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      row_cnt <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          row_cnt <= '0;
          if (accept) begin
            if (in_bad) begin
              done <= 1'b1;
            end else begin
              state <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          row_cnt <= row_cnt + CNT_W'(1);
          if (row_cnt == CNT_W'(DIGITS - 1)) begin
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (cy == '0) begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: operand load, row steps with a one-digit shift, carry settling.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < DIGITS; i++) begin
            mcand[i]  <= multiplicand_digits[4*i +: 4];
            mplier[i] <= multiplier_digits[4*i +: 4];
          end
          hi <= '0;
          cy <= '0;
          lo <= '0;
        end
      end
      ST_ROW: begin
        // Lowest position is final; it moves into the low half.
        lo[DIGITS-1] <= row_sum[0];
        for (int j = 0; j < DIGITS - 1; j++) begin
          lo[j]     <= lo[j+1];
          hi[j]     <= row_sum[j+1];
          mplier[j] <= mplier[j+1];
        end
        hi[DIGITS-1]     <= row_top;
        mplier[DIGITS-1] <= 4'd0;
        cy               <= row_carry;
      end
      ST_RESOLVE: begin
        // Move each saved carry up one place; the top carry is always zero.
        hi    <= row_sum;
        cy[0] <= 2'd0;
        for (int j = 1; j < DIGITS; j++) begin
          cy[j] <= row_carry[j-1];
        end
      end
      ST_COUNT: begin
      end
      default: begin
      end
    endcase
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && in_bad) begin
      product_upper      <= '0;
      product_lower      <= '0;
      significant_digits <= SIG_W'(1);
      bad_digit          <= 1'b1;
    end else if (state == ST_COUNT) begin
      product_upper      <= full[PRODUCT_DIGITS-1:WORD_DIGITS];
      product_lower      <= full[WORD_DIGITS-1:0];
      significant_digits <= sig_count;
      bad_digit          <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // A result is only shown while the sequencer is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while busy");

  // Work only begins on a start request.
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // All saved carries are settled before the digit count.
  a_carries_settled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COUNT) |-> (cy == '0))
    else $error("carries pending at digit count");

  // A flagged item reports a zero product.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_digit) |-> (product_upper == '0 && product_lower == '0))
    else $error("bad item with nonzero product");
`endif

endmodule

/* tb/sv/tb_bcd_long_multiplier.sv */
// Self-checking testbench for the BCD long multiplier: directed and random items.
// Depends on rtl/bcdm_pkg.sv and the bcd_long_multiplier top level.
// A scoreboard class predicts each product; plain tasks drive start and the operands.
module tb_bcd_long_multiplier;

  localparam int NDIG = bcdm_pkg::WORD_DIGITS;
  localparam int W    = bcdm_pkg::WORD_W;
  localparam int SW   = bcdm_pkg::SIG_W;

  typedef logic [W-1:0] word_t;

  // One predicted result, in the same fields as the result ports.
  typedef struct packed {
    word_t                     upper;
    word_t                     lower;
    logic [bcdm_pkg::SIG_W-1:0] sig;
    logic                      bad;
  } product_t;

  // Holds the products still owed by the block and checks each result in order.
  class product_board;
    product_t owed_q[$];
    int       errors;
    int       checked;
    int       taken;
    int       taken_bad;
    int       full_width;

    // Long multiplication by column sums, then one decimal carry pass.
    function product_t bcd_multiply(word_t a, word_t m);
      int unsigned da[NDIG];
      int unsigned dm[NDIG];
      int unsigned col[2*NDIG];
      int unsigned carry;
      product_t    r;
      r = '0;
      for (int k = 0; k < NDIG; k++) begin
        da[k] = {28'd0, a[4*k +: 4]};
        dm[k] = {28'd0, m[4*k +: 4]};
        if (da[k] > 9 || dm[k] > 9) r.bad = 1'b1;
      end
      r.sig = SW'(1);
      if (r.bad) return r;
      for (int k = 0; k < 2*NDIG; k++) col[k] = 0;
      for (int i = 0; i < NDIG; i++) begin
        for (int j = 0; j < NDIG; j++) col[i+j] += da[j] * dm[i];
      end
      carry = 0;
      for (int k = 0; k < 2*NDIG; k++) begin
        col[k] += carry;
        carry   = col[k] / 10;
        col[k]  = col[k] % 10;
        if (col[k] != 0) r.sig = SW'(k + 1);
        if (k < NDIG) r.lower[4*k +: 4] = 4'(col[k]);
        else          r.upper[4*(k-NDIG) +: 4] = 4'(col[k]);
      end
      return r;
    endfunction

    // An item was taken by the block: queue its product.
    function void note(word_t a, word_t m);
      product_t p;
      p = bcd_multiply(a, m);
      owed_q.push_back(p);
      taken++;
      if (p.bad) taken_bad++;
      if (p.sig == 2*NDIG) full_width++;
    endfunction

    function void report(string what, product_t want, product_t got);
      errors++;
      if (errors <= 10)
        $display("MISMATCH %s: want %h_%h sig=%0d bad=%b, got %h_%h sig=%0d bad=%b",
                 what, want.upper, want.lower, want.sig, want.bad,
                 got.upper, got.lower, got.sig, got.bad);
    endfunction

    // A result was strobed: compare it field by field with the oldest product owed.
    function void check(word_t upper, word_t lower, logic [bcdm_pkg::SIG_W-1:0] sig, logic bad);
      product_t got;
      product_t want;
      got = '{upper, lower, sig, bad};
      checked++;
      if (owed_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = owed_q.pop_front();
      if (got.bad !== want.bad) report("bad_digit", want, got);
      else if (got.sig !== want.sig) report("significant_digits", want, got);
      else if (got.upper !== want.upper) report("product_upper", want, got);
      else if (got.lower !== want.lower) report("product_lower", want, got);
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  word_t multiplicand_digits = '0;
  word_t multiplier_digits = '0;
  logic  done;
  word_t product_upper;
  word_t product_lower;
  logic [bcdm_pkg::SIG_W-1:0] significant_digits;
  logic  bad_digit;

  product_board board;
  int burst_left = 0;

  bcd_long_multiplier #(.DIGITS(NDIG)) u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .multiplicand_digits (multiplicand_digits),
    .multiplier_digits   (multiplier_digits),
    .done                (done),
    .product_upper       (product_upper),
    .product_lower       (product_lower),
    .significant_digits  (significant_digits),
    .bad_digit           (bad_digit)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watch both sides at each edge; results are checked before new items are noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check(product_upper, product_lower, significant_digits, bad_digit);
      if (start && !busy) board.note(multiplicand_digits, multiplier_digits);
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic drive_item(input word_t a, input word_t m);
    start               <= 1'b1;
    multiplicand_digits <= a;
    multiplier_digits   <= m;
    do @(posedge clk); while (busy);
  endtask

  // Idle for a random gap, mostly short, a few long, with bursts of none at all.
  task automatic idle_gap();
    int g;
    int r;
    r = $urandom_range(99, 0);
    if (burst_left > 0) begin
      burst_left--;
      g = 0;
    end else if (r < 3) begin
      burst_left = $urandom_range(60, 20);
      g = 0;
    end else if (r < 55) g = 0;
    else if (r < 90) g = $urandom_range(3, 1);
    else g = $urandom_range(40, 8);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) begin
        multiplicand_digits <= {$urandom(), $urandom()};
        multiplier_digits   <= {$urandom(), $urandom()};
        @(posedge clk);
      end
    end
  endtask

  // Random valid BCD operand: mostly random length, some short, zero or all nines.
  function automatic word_t rand_bcd();
    word_t v;
    int    len;
    int    r;
    v = '0;
    r = $urandom_range(99, 0);
    len = (r < 60) ? $urandom_range(NDIG, 1) : (r < 75) ? $urandom_range(4, 1) : NDIG;
    if (r >= 75 && r < 85) return '0;
    for (int k = 0; k < len; k++)
      v[4*k +: 4] = (r >= 85) ? 4'd9 : 4'($urandom_range(9, 0));
    return v;
  endfunction

  initial begin : stimulus
    word_t dir_a[$];
    word_t dir_m[$];
    word_t a;
    word_t m;
    int    r;
    int    pos;
    int    waited;
    board = new();

    // Directed items: extremes, zero, carries across the halves and invalid digits.
    dir_a = '{64'h0, 64'h0, 64'h9999_9999_9999_9999, 64'h1, 64'h9999_9999_9999_9999,
              64'h1000_0000_0000_0000, 64'h9, 64'h1_2345_6789, 64'h5,
              64'h9999_9999_9999_9999, 64'hA, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
              64'h1234_5678_9012_3456, 64'h5000_0000_0000_0000, 64'h1,
              64'h0999_9999_9999_9999, 64'h1, 64'h8080_8080_8080_8080,
              64'hA000_0000_0000_0000, 64'h0000_0000_0000_00B0};
    dir_m = '{64'h0, 64'h9999_9999_9999_9999, 64'h9999_9999_9999_9999, 64'h1, 64'h1,
              64'h1000_0000_0000_0000, 64'h9, 64'h9_8765_4321, 64'h2, 64'h9,
              64'h1, 64'hF000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA,
              64'h6543_2109_8765_4321, 64'h2, 64'h8888_8888_8888_8888, 64'h1, 64'h0,
              64'h0808_0808_0808_0808, 64'h9, 64'h9999_9999_9999_9999};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_a[k]) begin
      drive_item(dir_a[k], dir_m[k]);
      idle_gap();
    end

    // Random items: mostly valid BCD, some with one invalid digit, some raw noise.
    for (int n = 0; n < 1850; n++) begin
      r = $urandom_range(99, 0);
      a = rand_bcd();
      m = rand_bcd();
      if (r >= 80 && r < 90) begin
        pos = $urandom_range(NDIG-1, 0);
        if ($urandom_range(1, 0)) a[4*pos +: 4] = 4'($urandom_range(15, 10));
        else                     m[4*pos +: 4] = 4'($urandom_range(15, 10));
      end else if (r >= 90) begin
        a = {$urandom(), $urandom()};
        m = {$urandom(), $urandom()};
      end
      drive_item(a, m);
      idle_gap();
    end
    start <= 1'b0;

    // Drain the outstanding result, then watch for stray strobes.
    waited = 0;
    while (board.owed_q.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (2*NDIG + 8) @(posedge clk);
    board.errors += board.owed_q.size();

    $display("Multiplied %0d items (%0d with invalid digits, %0d full 32-digit products).",
             board.taken, board.taken_bad, board.full_width);
    $display("Checked %0d results, %0d mismatches or missing results.",
             board.checked, board.errors);
    if (board.errors == 0) begin
      $display("tb_bcd_long_multiplier: done, clean");
    end else begin
      $display("tb_bcd_long_multiplier: done, errors");
    end
    $finish;
  end

  // Hard limit on run time in case the block stops answering.
  initial begin
    #4000000;
    $display("tb_bcd_long_multiplier: done, errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/bcdm_pkg.sv
rtl/bcdm_row_unit.sv
rtl/bcdm_digit_count.sv
rtl/bcd_long_multiplier.sv
tb/sv/tb_bcd_long_multiplier.sv
